// ===== rtl/sacch_pkg.sv =====
package sacch_pkg;

  // Word layout, MSB first: structure, RAN, data, CRC.
  localparam int unsigned WordW    = 32;
  localparam int unsigned CrcW     = 6;
  localparam int unsigned CrcBits  = 26;
  localparam int unsigned DataW    = 18;
  localparam int unsigned NumSlots = 4;
  localparam int unsigned FrameW   = DataW * NumSlots;

  localparam logic [CrcW-1:0] CrcSeed = 6'b111111;
  localparam logic [CrcW-1:0] CrcPoly = 6'b010011;
  localparam logic [1:0]      IdxFlip = 2'b11;

  typedef logic [CrcW-1:0] crc_cols_t [CrcBits];

  // Request from the pipeline to the fragment slots.
  typedef struct packed {
    logic             en;
    logic             clear;
    logic             crc_ok;
    logic [1:0]       idx;
    logic [DataW-1:0] data;
  } sacch_frag_req_t;

  // Slot state as it stands after the request.
  typedef struct packed {
    logic              stored;
    logic              complete;
    logic [FrameW-1:0] frame;
  } sacch_frag_res_t;

  // Bit-serial CRC, used only to build constant tables at elaboration.
  function automatic logic [CrcW-1:0] crc6_serial(logic [CrcBits-1:0] d,
                                                  logic [CrcW-1:0] seed);
    logic [CrcW-1:0] r;
    logic            fb;
    r = seed;
    for (int i = 0; i < CrcBits; i++) begin
      fb = r[CrcW-1] ^ d[CrcBits-1-i];
      if (fb) begin
        r = r ^ CrcPoly;
      end
      r = {r[CrcW-2:0], fb};
    end
    return r;
  endfunction

  // Contribution of each message bit to the CRC; the CRC is linear in the data.
  function automatic crc_cols_t crc6_columns();
    crc_cols_t cols;
    for (int i = 0; i < CrcBits; i++) begin
      cols[i] = crc6_serial(CrcBits'(1) << i, '0);
    end
    return cols;
  endfunction

endpackage

// ===== rtl/sacch_crc6.sv =====
module sacch_crc6
  import sacch_pkg::*;
(
  input  logic [WordW-1:0] word,
  output logic             match
);

  localparam crc_cols_t       CrcCols = crc6_columns();
  localparam logic [CrcW-1:0] CrcInit = crc6_serial('0, CrcSeed);

  logic [CrcW-1:0] crc;

  // XOR of the seed term and one column per set message bit.
  always_comb begin
    crc = CrcInit;
    for (int i = 0; i < CrcBits; i++) begin
      if (word[WordW-CrcBits+i]) begin
        crc = crc ^ CrcCols[i];
      end
    end
  end

  assign match = (crc == word[CrcW-1:0]);

endmodule

// ===== rtl/sacch_frag_store.sv =====
module sacch_frag_store
  import sacch_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  sacch_frag_req_t req,
  output sacch_frag_res_t res
);

  logic [DataW-1:0]    store_r [NumSlots];
  logic [NumSlots-1:0] filled_r;
  logic [NumSlots-1:0] filled_nxt;
  logic [DataW-1:0]    store_view [NumSlots];
  logic                take;

  // Ordering rule: slot 0 always, a later slot only after its predecessor.
  always_comb begin
    take = 1'b0;
    if (!req.clear && req.crc_ok) begin
      if (req.idx == 2'd0) begin
        take = 1'b1;
      end else begin
        take = filled_r[req.idx - 2'd1];
      end
    end
  end

  // Slot flags and data as seen after this request.
  always_comb begin
    filled_nxt = filled_r;
    if (req.clear) begin
      filled_nxt = '0;
    end else if (take) begin
      filled_nxt[req.idx] = 1'b1;
    end
    for (int i = 0; i < NumSlots; i++) begin
      store_view[i] = store_r[i];
    end
    if (take) begin
      store_view[req.idx] = req.data;
    end
  end

  assign res.stored   = take;
  assign res.complete = &filled_nxt;
  assign res.frame    = {store_view[0], store_view[1], store_view[2], store_view[3]};

  // Flags are control state and reset; the data slots are written before use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
    end else if (req.en) begin
      filled_r <= filled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en && take) begin
      store_r[req.idx] <= req.data;
    end
  end

endmodule

// ===== rtl/sacch_crc_superframe_assembler.sv =====
// SACCH superframe assembler. Each item is either a decoded 32-bit SACCH
// word (in_mode = 0) or a clear command (in_mode = 1). A word whose CRC-6
// checks is stored as an 18-bit fragment in the slot named by its structure
// bits, if that slot is 0 or its predecessor is filled, and once all four
// slots hold data every result carries the 72-bit superframe and its
// decoded fields until the next clear. The block takes one item per cycle
// while the result side does not stall, and returns exactly one result per
// item. The item is captured in an input register, and the CRC check and
// slot update run combinationally between that register and the result
// register, which drives the outputs. Stalls on the result side propagate
// back through in_stall without losing or repeating an item.
module sacch_crc_superframe_assembler
  import sacch_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_sacch_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_crc_ok,
  output logic [1:0]  out_fragment_index,
  output logic        out_fragment_stored,
  output logic        out_complete,
  output logic [63:0] out_superframe_high,
  output logic [7:0]  out_superframe_low,
  output logic [5:0]  out_message_type,
  output logic [2:0]  out_call_type,
  output logic [15:0] out_source_unit,
  output logic [15:0] out_destination_unit
);

  logic             s1_valid_r;
  logic             s1_mode_r;
  logic [WordW-1:0] s1_word_r;
  logic             s1_move;
  logic             s1_load;
  logic             out_valid_r;
  logic             crc_match;
  sacch_frag_req_t  frag_req;
  sacch_frag_res_t  frag_res;
  logic [63:0]      hi_nxt;
  logic [7:0]       lo_nxt;

  // Handshake: the input stage drains when the result register is free.
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_mode_r <= in_mode;
      s1_word_r <= in_sacch_word;
    end
  end

  sacch_crc6 u_crc (
    .word  (s1_word_r),
    .match (crc_match)
  );

  // Slot update request for the item leaving the input stage.
  always_comb begin
    frag_req.en     = s1_move;
    frag_req.clear  = s1_mode_r;
    frag_req.crc_ok = crc_match && !s1_mode_r;
    frag_req.idx    = s1_mode_r ? 2'd0 : (s1_word_r[WordW-1 -: 2] ^ IdxFlip);
    frag_req.data   = s1_word_r[CrcW +: DataW];
  end

  sacch_frag_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (frag_req),
    .res   (frag_res)
  );

  // Superframe fields are zero until all slots are filled.
  always_comb begin
    hi_nxt = '0;
    lo_nxt = '0;
    if (frag_res.complete) begin
      hi_nxt = frag_res.frame[FrameW-1 -: 64];
      lo_nxt = frag_res.frame[7:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_crc_ok           <= frag_req.crc_ok;
      out_fragment_index   <= frag_req.idx;
      out_fragment_stored  <= frag_res.stored;
      out_complete         <= frag_res.complete && !s1_mode_r;
      out_superframe_high  <= hi_nxt;
      out_superframe_low   <= lo_nxt;
      out_message_type     <= hi_nxt[61:56];
      out_call_type        <= hi_nxt[47:45];
      out_source_unit      <= hi_nxt[39:24];
      out_destination_unit <= hi_nxt[23:8];
    end
  end

  assign out_valid = out_valid_r;

  // A fragment is never stored without a good CRC.
  a_stored_needs_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fragment_stored |-> out_crc_ok)
    else $error("fragment stored without a CRC match");

  // Storing the last fragment always completes the superframe.
  a_last_completes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fragment_stored && (out_fragment_index == 2'd3) |-> out_complete)
    else $error("last fragment stored but superframe not complete");

  // An item held in the input stage is not dropped while the output stalls.
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> s1_valid_r && $stable(s1_word_r))
    else $error("input stage item lost during stall");

  // Superframe data shows only with a complete result.
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_complete |-> (out_superframe_high == '0) && (out_superframe_low == '0))
    else $error("superframe data present on an incomplete result");

endmodule

// ===== tb/sacch_crc_superframe_assembler_tb.sv =====
`timescale 1ns / 100ps

module sacch_crc_superframe_assembler_tb;
  import sacch_pkg::*;

  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;
  localparam int unsigned REPORT_CAP = 100;

  // One expected result item.
  typedef struct packed {
    logic        crc_ok;
    logic [1:0]  frag_idx;
    logic        stored;
    logic        complete;
    logic [63:0] sf_high;
    logic [7:0]  sf_low;
    logic [5:0]  msg_type;
    logic [2:0]  call_type;
    logic [15:0] src_unit;
    logic [15:0] dst_unit;
  } sacch_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [31:0] in_sacch_word;
  logic        out_valid;
  logic        out_stall;
  logic        out_crc_ok;
  logic [1:0]  out_fragment_index;
  logic        out_fragment_stored;
  logic        out_complete;
  logic [63:0] out_superframe_high;
  logic [7:0]  out_superframe_low;
  logic [5:0]  out_message_type;
  logic [2:0]  out_call_type;
  logic [15:0] out_source_unit;
  logic [15:0] out_destination_unit;

  // Shadow copy of the fragment slots.
  logic [DataW-1:0]    frag_mem [NumSlots];
  logic [NumSlots-1:0] slot_mask;

  sacch_result_t pending_results [$];
  int unsigned   mismatch_count;
  int unsigned   items_sent;
  logic          no_idle;

  sacch_crc_superframe_assembler dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_sacch_word        (in_sacch_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_crc_ok           (out_crc_ok),
    .out_fragment_index   (out_fragment_index),
    .out_fragment_stored  (out_fragment_stored),
    .out_complete         (out_complete),
    .out_superframe_high  (out_superframe_high),
    .out_superframe_low   (out_superframe_low),
    .out_message_type     (out_message_type),
    .out_call_type        (out_call_type),
    .out_source_unit      (out_source_unit),
    .out_destination_unit (out_destination_unit)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // CRC-6 over the top 26 bits, MSB first. The shift and the conditional
  // polynomial XOR are folded into one step.
  function automatic logic [CrcW-1:0] crc6_of(logic [WordW-1:0] w);
    logic [CrcW-1:0] r;
    logic            fb;
    r = CrcSeed;
    for (int i = 0; i < CrcBits; i++) begin
      fb = r[CrcW-1] ^ w[WordW-1-i];
      r  = (r << 1) ^ ({CrcW{fb}} & {CrcPoly[CrcW-2:0], 1'b1});
    end
    return r;
  endfunction

  // Build a word with a correct CRC for the given fragment index.
  function automatic logic [WordW-1:0] make_word(logic [1:0] idx, logic [5:0] ran,
                                                 logic [DataW-1:0] data);
    logic [WordW-1:0] w;
    w      = {idx ^ IdxFlip, ran, data, 6'b0};
    w[5:0] = crc6_of(w);
    return w;
  endfunction

  // Predict the result of one item and update the shadow slots.
  function automatic sacch_result_t assemble_step(logic mode, logic [WordW-1:0] w);
    sacch_result_t     r;
    logic [1:0]        prev;
    logic [FrameW-1:0] frame;
    r = '0;
    if (mode == MODE_CLEAR) begin
      slot_mask = '0;
      return r;
    end
    r.frag_idx = w[31:30] ^ IdxFlip;
    prev = r.frag_idx - 2'd1;
    if (crc6_of(w) == w[5:0]) begin
      r.crc_ok = 1'b1;
      if (r.frag_idx == 2'd0 || slot_mask[prev]) begin
        frag_mem[r.frag_idx]  = w[CrcW +: DataW];
        slot_mask[r.frag_idx] = 1'b1;
        r.stored = 1'b1;
      end
    end
    if (&slot_mask) begin
      frame       = {frag_mem[0], frag_mem[1], frag_mem[2], frag_mem[3]};
      r.complete  = 1'b1;
      r.sf_high   = frame[71:8];
      r.sf_low    = frame[7:0];
      r.msg_type  = r.sf_high[61:56];
      r.call_type = r.sf_high[47:45];
      r.src_unit  = r.sf_high[39:24];
      r.dst_unit  = r.sf_high[23:8];
    end
    return r;
  endfunction

  // Mostly short gaps, some medium, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) begin
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    end
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Send one item. Entered and left at a falling edge.
  task automatic send_item(logic mode, logic [WordW-1:0] w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_sacch_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(assemble_step(mode, w));
    items_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // Stored data out of reset, rejected fragments, bad CRCs and a clear.
  task automatic test_reset_and_rejects();
    send_item(MODE_PUSH, make_word(2'd1, 6'h01, 18'h00001));
    send_item(MODE_PUSH, make_word(2'd3, 6'h3F, 18'h3FFFF));
    send_item(MODE_PUSH, make_word(2'd0, 6'h00, 18'h12345) ^ 32'h1);
    send_item(MODE_PUSH, 32'h0000_0000);
    send_item(MODE_PUSH, 32'hFFFF_FFFF);
    send_item(MODE_CLEAR, 32'hFFFF_FFFF);
  endtask

  // Fragments in order with extreme contents, then the sticky complete flag.
  task automatic test_in_order_assembly();
    send_item(MODE_PUSH, make_word(2'd0, 6'h00, 18'h00000));
    send_item(MODE_PUSH, make_word(2'd1, 6'h3F, 18'h3FFFF));
    send_item(MODE_PUSH, make_word(2'd2, 6'h15, 18'h2AAAA));
    send_item(MODE_PUSH, make_word(2'd3, 6'h2A, 18'h15555));
    send_item(MODE_PUSH, make_word(2'd2, 6'h00, 18'h3FFFF));
    send_item(MODE_PUSH, make_word(2'd3, 6'h11, 18'h0F0F0) ^ 32'h8000_0000);
    send_item(MODE_CLEAR, 32'h0000_0000);
    send_item(MODE_PUSH, make_word(2'd0, 6'h3F, 18'h3FFFF));
  endtask

  // A later fragment needs the slot before it.
  task automatic test_ordering_rule();
    send_item(MODE_CLEAR, 32'h5A5A_A5A5);
    send_item(MODE_PUSH, make_word(2'd2, 6'h05, 18'h00F00));
    send_item(MODE_PUSH, make_word(2'd0, 6'h05, 18'h3C003));
    send_item(MODE_PUSH, make_word(2'd2, 6'h05, 18'h00F00));
    send_item(MODE_PUSH, make_word(2'd1, 6'h05, 18'h1FFFE));
    send_item(MODE_PUSH, make_word(2'd3, 6'h05, 18'h3FFFF));
    send_item(MODE_PUSH, make_word(2'd2, 6'h05, 18'h00F00));
    send_item(MODE_PUSH, make_word(2'd3, 6'h05, 18'h3FFFF));
    send_item(MODE_PUSH, make_word(2'd0, 6'h3F, 18'h3FFFF));
  endtask

  // One superframe in order with random content and occasional bit errors.
  task automatic send_superframe(logic clear_first, int unsigned err_pct);
    logic [WordW-1:0] w;
    if (clear_first) begin
      send_item(MODE_CLEAR, $urandom());
    end
    for (int k = 0; k < NumSlots; k++) begin
      w = make_word(2'(k), 6'($urandom()), 18'($urandom()));
      if ($urandom_range(0, 99) < err_pct) begin
        w = w ^ (32'h1 << $urandom_range(0, 31));
      end
      send_item(MODE_PUSH, w);
    end
    // Extra pushes after completion overwrite slots.
    repeat ($urandom_range(0, 2)) begin
      send_item(MODE_PUSH, make_word(2'($urandom()), 6'($urandom()), 18'($urandom())));
    end
  endtask

  // Back-to-back items with no gaps and no result stalls.
  task automatic test_back_to_back(int unsigned count);
    no_idle = 1'b1;
    repeat (count / 5) send_superframe(1'b1, 5);
    no_idle = 1'b0;
  endtask

  // Mostly well-formed superframes, the rest noise and out-of-order fragments.
  task automatic test_random_traffic(int unsigned target);
    int unsigned start;
    int unsigned roll;
    start = items_sent;
    while (items_sent - start < target) begin
      no_idle = ($urandom_range(0, 9) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        send_superframe(roll < 35, 10);
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 6)) begin
          send_item($urandom_range(0, 9) == 0, $urandom());
        end
      end else begin
        repeat ($urandom_range(2, 6)) begin
          send_item(MODE_PUSH, make_word(2'($urandom()), 6'($urandom()), 18'($urandom())));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side stalls in runs of random length.
  initial begin : stall_gen
    int unsigned run;
    out_stall = 1'b0;
    forever begin
      run = pick_gap();
      if (run > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (run - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    sacch_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected", 64'd0, 64'd0);
      end else begin
        want = pending_results.pop_front();
        check_field("crc_ok", 64'(out_crc_ok), 64'(want.crc_ok));
        check_field("fragment_index", 64'(out_fragment_index), 64'(want.frag_idx));
        check_field("fragment_stored", 64'(out_fragment_stored), 64'(want.stored));
        check_field("complete", 64'(out_complete), 64'(want.complete));
        check_field("superframe_high", out_superframe_high, want.sf_high);
        check_field("superframe_low", 64'(out_superframe_low), 64'(want.sf_low));
        check_field("message_type", 64'(out_message_type), 64'(want.msg_type));
        check_field("call_type", 64'(out_call_type), 64'(want.call_type));
        check_field("source_unit", 64'(out_source_unit), 64'(want.src_unit));
        check_field("destination_unit", 64'(out_destination_unit), 64'(want.dst_unit));
      end
    end
  end

  // Reset, then the tests in turn.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_PUSH;
    in_sacch_word  = '0;
    no_idle        = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    slot_mask      = '0;
    for (int i = 0; i < NumSlots; i++) frag_mem[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_and_rejects();
    wait_for_results();
    test_in_order_assembly();
    wait_for_results();
    test_ordering_rule();
    wait_for_results();
    test_back_to_back(100);
    test_random_traffic(1800);
    wait_for_results();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sacch_pkg.sv
rtl/sacch_crc6.sv
rtl/sacch_frag_store.sv
rtl/sacch_crc_superframe_assembler.sv
tb/sacch_crc_superframe_assembler_tb.sv
